// ===== hdl/oversampled_pfb_front_end_core_assert.svh =====
// Assertion macros for the oversampled filter bank front end.
// Used by the top level; no other dependencies.
`ifndef OVERSAMPLED_PFB_FRONT_END_CORE_ASSERT_SVH
`define OVERSAMPLED_PFB_FRONT_END_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OPFB_ASSERT_NOW(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define OPFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OPFB_ASSERT_NOW(lbl, prop)
`define OPFB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/opfb_pkg.sv =====
// Shared types for the oversampled filter bank front end.
// No dependencies.
package opfb_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_OUT
  } opfb_state_e;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned FRAC_W   = 15;

endpackage

// ===== hdl/opfb_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module opfb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/oversampled_pfb_front_end_core.sv =====
// Oversampled polyphase filter bank front end: delay line, branch MACs, rotation.
// Depends on opfb_pkg, opfb_ram and oversampled_pfb_front_end_core_assert.svh.
//
// After reset the block clears the delay line and coefficient memories and accepts
// no item meanwhile. A coefficient load or a sample that does not close a frame
// leaves the block ready for the next item. The sample that closes a frame starts
// BRANCHES branch sums in output (rotated) order; each branch runs TAPS_PER_BRANCH
// multiply-accumulates through the shared multiplier pair, one per cycle as set by
// the single read port of each memory, then passes through the memory read, product
// and accumulator registers before it is offered at the output. Samples are written
// straight into a circular delay line, so no frame shift is ever done.
`include "oversampled_pfb_front_end_core_assert.svh"
module oversampled_pfb_front_end_core #(
  parameter int unsigned BRANCHES        = 32,
  parameter int unsigned DECIMATION      = 24,
  parameter int unsigned TAPS_PER_BRANCH = 8,
  parameter int unsigned ROTATION_STATES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_re[15:0], sample_im[31:16], coeff_index[39:32], coeff_value[55:40]
  input  logic [55:0] s_axis_tdata,
  // opcode[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_re[31:0], out_im[63:32]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import opfb_pkg::*;

  localparam int unsigned LINE  = BRANCHES * TAPS_PER_BRANCH;
  localparam int unsigned AW    = $clog2(LINE);
  localparam int unsigned MW    = $clog2(BRANCHES);
  localparam int unsigned PW    = (TAPS_PER_BRANCH > 1) ? $clog2(TAPS_PER_BRANCH) : 1;
  localparam int unsigned CW    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int unsigned RW    = (ROTATION_STATES > 1) ? $clog2(ROTATION_STATES) : 1;
  localparam int unsigned ACC_W = 2 * SAMPLE_W + $clog2(TAPS_PER_BRANCH) + 1;
  localparam int unsigned DMOD  = DECIMATION % LINE;
  localparam int unsigned BSTEP = LINE - DMOD;
  localparam int unsigned BINIT = (LINE - DMOD) % LINE;
  localparam int unsigned RSTEP = (BRANCHES - (DECIMATION % BRANCHES)) % BRANCHES;

  // add two addresses below LINE, wrapping once
  function automatic logic [AW-1:0] line_add(logic [AW:0] a, logic [AW:0] b);
    logic [AW+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+2)'(LINE)) begin
      s = s - (AW+2)'(LINE);
    end
    return s[AW-1:0];
  endfunction

  opfb_state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] rot_q, rot_d;
  logic [MW-1:0] shift_q, shift_d;
  logic [MW-1:0] br_q, br_d;
  logic [MW-1:0] oi_q, oi_d;
  logic [PW-1:0] p_q, p_d;
  logic [AW-1:0] lidx_q, lidx_d;

  // MAC pipeline flags
  logic v1_q, f1_q, l1_q;
  logic v2_q, f2_q, l2_q;
  logic done_q;
  logic signed [2*SAMPLE_W-1:0] prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]      acc_re_q, acc_im_q;

  logic                     out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]  out_re_q, out_im_q;
  logic                     out_last_q;

  // memory ports
  logic                  dl_we, cf_we;
  logic [AW-1:0]         dl_waddr, cf_waddr, dl_raddr;
  logic [2*SAMPLE_W-1:0] dl_wdata, dl_rdata;
  logic [SAMPLE_W-1:0]   cf_wdata, cf_rdata;

  logic                    accept;
  logic [0:0]              in_opcode;
  logic [SAMPLE_W-1:0]     in_re, in_im, in_coeff;
  logic [7:0]              in_cidx;
  logic [MW:0]             br_next, sh_next;
  logic [MW-1:0]           start_br;

  assign in_opcode = s_axis_tuser;
  assign in_re     = s_axis_tdata[15:0];
  assign in_im     = s_axis_tdata[31:16];
  assign in_cidx   = s_axis_tdata[39:32];
  assign in_coeff  = s_axis_tdata[55:40];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_im_q, out_re_q};
  assign m_axis_tlast  = out_last_q;

  assign br_next  = {1'b0, br_q} + (MW+1)'(1);
  assign sh_next  = {1'b0, shift_q} + (MW+1)'(RSTEP);
  assign start_br = (shift_q == '0) ? '0 : MW'(BRANCHES - 32'(shift_q));

  opfb_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(LINE)) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  opfb_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE)) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .raddr_i (lidx_q),
    .rdata_o (cf_rdata)
  );

  assign dl_raddr = line_add({1'b0, base_q}, {1'b0, lidx_q});

  // sequencer: next state, memory writes, counters
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    rot_d       = rot_q;
    shift_d     = shift_q;
    br_d        = br_q;
    oi_d        = oi_q;
    p_d         = p_q;
    lidx_d      = lidx_q;
    out_valid_d = out_valid_q;
    dl_we       = 1'b0;
    cf_we       = 1'b0;
    dl_waddr    = line_add({1'b0, base_q}, (AW+1)'(cnt_q));
    dl_wdata    = {in_im, in_re};
    cf_waddr    = AW'(in_cidx);
    cf_wdata    = in_coeff;
    case (state_q)
      ST_CLEAR: begin
        dl_we    = 1'b1;
        cf_we    = 1'b1;
        dl_waddr = clr_q;
        cf_waddr = clr_q;
        dl_wdata = '0;
        cf_wdata = '0;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(LINE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode[0]) begin
            // drop loads beyond the tap count
            cf_we = (32'(in_cidx) < LINE);
          end else begin
            // frame positions past the line length never enter it
            dl_we = (32'(cnt_q) < LINE);
            if (cnt_q == CW'(DECIMATION - 1)) begin
              cnt_d   = '0;
              br_d    = start_br;
              lidx_d  = AW'(start_br);
              p_d     = '0;
              oi_d    = '0;
              state_d = ST_MAC;
            end else begin
              cnt_d = cnt_q + CW'(1);
            end
          end
        end
      end
      ST_MAC: begin
        // issue one tap of the current branch
        if (p_q == PW'(TAPS_PER_BRANCH - 1)) begin
          state_d = ST_WAIT;
        end else begin
          p_d    = p_q + PW'(1);
          lidx_d = AW'((AW+1)'(lidx_q) + (AW+1)'(BRANCHES));
        end
      end
      ST_WAIT: begin
        if (done_q) begin
          out_valid_d = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (oi_q == MW'(BRANCHES - 1)) begin
            // frame done: retire base, advance rotation
            base_d  = line_add({1'b0, base_q}, (AW+1)'(BSTEP));
            state_d = ST_IDLE;
            if (rot_q == RW'(ROTATION_STATES - 1)) begin
              rot_d   = '0;
              shift_d = '0;
            end else begin
              rot_d   = rot_q + RW'(1);
              shift_d = (sh_next >= (MW+1)'(BRANCHES)) ?
                        MW'(sh_next - (MW+1)'(BRANCHES)) : MW'(sh_next);
            end
          end else begin
            oi_d    = oi_q + MW'(1);
            br_d    = (br_next == (MW+1)'(BRANCHES)) ? '0 : MW'(br_next);
            lidx_d  = AW'((br_next == (MW+1)'(BRANCHES)) ? '0 : br_next);
            p_d     = '0;
            state_d = ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      base_q      <= AW'(BINIT);
      cnt_q       <= '0;
      rot_q       <= '0;
      shift_q     <= '0;
      br_q        <= '0;
      oi_q        <= '0;
      p_q         <= '0;
      lidx_q      <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      rot_q       <= rot_d;
      shift_q     <= shift_d;
      br_q        <= br_d;
      oi_q        <= oi_d;
      p_q         <= p_d;
      lidx_q      <= lidx_d;
      out_valid_q <= out_valid_d;
      v1_q        <= (state_q == ST_MAC);
      v2_q        <= v1_q;
      done_q      <= v2_q && l2_q;
    end
  end

  // multiply and accumulate datapath
  always_ff @(posedge clk_i) begin
    f1_q      <= (p_q == '0);
    l1_q      <= (p_q == PW'(TAPS_PER_BRANCH - 1));
    f2_q      <= f1_q;
    l2_q      <= l1_q;
    prod_re_q <= $signed(cf_rdata) * $signed(dl_rdata[SAMPLE_W-1:0]);
    prod_im_q <= $signed(cf_rdata) * $signed(dl_rdata[2*SAMPLE_W-1:SAMPLE_W]);
    if (v2_q) begin
      acc_re_q <= (f2_q ? ACC_W'(0) : acc_re_q) + ACC_W'(prod_re_q);
      acc_im_q <= (f2_q ? ACC_W'(0) : acc_im_q) + ACC_W'(prod_im_q);
    end
    // floor shift; the sum of TAPS_PER_BRANCH products always fits after it
    if (state_q == ST_WAIT && done_q) begin
      out_re_q   <= OUT_W'(acc_re_q >>> FRAC_W);
      out_im_q   <= OUT_W'(acc_im_q >>> FRAC_W);
      out_last_q <= (oi_q == MW'(BRANCHES - 1));
    end
  end

  `OPFB_ASSERT_NOW(a_no_accept_while_out, !(s_axis_tready && m_axis_tvalid))
  `OPFB_ASSERT_NOW(a_cnt_range, 32'(cnt_q) < DECIMATION)
  `OPFB_ASSERT_NOW(a_rot_zero_shift, (rot_q != '0) || (shift_q == '0))
  `OPFB_ASSERT_NEXT(a_last_to_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                    state_q == ST_IDLE)

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the oversampled polyphase filter bank front end core.
// Self-checking: drives samples and coefficient loads, predicts branch sums.
// Depends on oversampled_pfb_front_end_core and opfb_pkg.
`timescale 1ns / 100ps
module tb;
  import opfb_pkg::*;

  localparam int unsigned NBR   = 32;
  localparam int unsigned NDEC  = 24;
  localparam int unsigned NTAP  = 8;
  localparam int unsigned NROT  = 4;
  localparam int unsigned NLINE = NBR * NTAP;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEFF  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] coeff_value;
    logic [7:0]  coeff_index;
    logic [15:0] im;
    logic [15:0] re;
  } pfb_item_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } branch_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  oversampled_pfb_front_end_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // Predictor state
  logic signed [15:0] pred_line_re [NLINE];
  logic signed [15:0] pred_line_im [NLINE];
  logic signed [15:0] pred_coeff [NLINE];
  logic signed [15:0] pred_frame_re [NDEC];
  logic signed [15:0] pred_frame_im [NDEC];
  int unsigned        pred_fill;
  int unsigned        pred_rot;

  pfb_item_t   pending_items[$];
  branch_out_t expected_outs[$];
  int unsigned mismatches;
  bit          rx_hold;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  function automatic logic [31:0] scale_to_out(logic signed [63:0] acc);
    logic signed [63:0] r;
    r = acc >>> 15;
    if (r > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (r < -64'sh8000_0000) return 32'h8000_0000;
    return r[31:0];
  endfunction

  // Apply one accepted item to the predictor, queue the branch outputs it causes
  task automatic predict_branches(pfb_item_t it);
    logic signed [63:0] acc_re [NBR];
    logic signed [63:0] acc_im [NBR];
    int unsigned idx, shift, src;
    branch_out_t o;
    if (it.op == OP_COEFF) begin
      if (it.coeff_index < NLINE) pred_coeff[it.coeff_index] = it.coeff_value;
      return;
    end
    pred_frame_re[pred_fill] = it.re;
    pred_frame_im[pred_fill] = it.im;
    pred_fill++;
    if (pred_fill < NDEC) return;
    pred_fill = 0;
    for (int k = NLINE - 1; k >= NDEC; k--) begin
      pred_line_re[k] = pred_line_re[k - NDEC];
      pred_line_im[k] = pred_line_im[k - NDEC];
    end
    for (int k = 0; k < NDEC; k++) begin
      pred_line_re[k] = pred_frame_re[k];
      pred_line_im[k] = pred_frame_im[k];
    end
    for (int m = 0; m < NBR; m++) begin
      acc_re[m] = 0;
      acc_im[m] = 0;
      for (int p = 0; p < NTAP; p++) begin
        idx = p * NBR + m;
        acc_re[m] += 64'(pred_coeff[idx]) * 64'(pred_line_re[idx]);
        acc_im[m] += 64'(pred_coeff[idx]) * 64'(pred_line_im[idx]);
      end
    end
    shift = (pred_rot * ((NBR - (NDEC % NBR)) % NBR)) % NBR;
    for (int i = 0; i < NBR; i++) begin
      src = (NBR - shift + i) % NBR;
      o.re = scale_to_out(acc_re[src]);
      o.im = scale_to_out(acc_im[src]);
      o.last = (i == NBR - 1);
      expected_outs.push_back(o);
    end
    pred_rot = (pred_rot + 1) % NROT;
  endtask

  function automatic pfb_item_t make_sample(logic [15:0] re, logic [15:0] im);
    pfb_item_t it;
    it.op = OP_SAMPLE;
    it.re = re;
    it.im = im;
    it.coeff_index = 8'($urandom);
    it.coeff_value = 16'($urandom);
    return it;
  endfunction

  function automatic pfb_item_t make_coeff(logic [7:0] ix, logic [15:0] v);
    pfb_item_t it;
    it.op = OP_COEFF;
    it.coeff_index = ix;
    it.coeff_value = v;
    it.re = 16'($urandom);
    it.im = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer the head of the pending queue, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_branches(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (s_axis_tvalid && !s_axis_tready
          || $urandom_range(0, 99) >= tx_idle_pct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_items[0].coeff_value, pending_items[0].coeff_index,
                          pending_items[0].im, pending_items[0].re};
        s_axis_tuser  <= pending_items[0].op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: compare each output item with the oldest expectation
  always @(posedge clk_i) begin
    branch_out_t exp_o;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item %h", m_axis_tdata);
      end else begin
        exp_o = expected_outs.pop_front();
        if (exp_o.re !== m_axis_tdata[31:0] || exp_o.im !== m_axis_tdata[63:32]
            || exp_o.last !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp re=%h im=%h last=%b got re=%h im=%h last=%b",
                     exp_o.re, exp_o.im, exp_o.last,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_outs.size() > 0) @(posedge clk_i);
  endtask

  // Stimulus and end of run
  initial begin
    for (int k = 0; k < NLINE; k++) begin
      pred_line_re[k] = 0; pred_line_im[k] = 0; pred_coeff[k] = 0;
    end
    pred_fill = 0;
    pred_rot = 0;
    mismatches = 0;
    rx_hold = 0;
    tx_idle_pct = 35;
    rx_idle_pct = 35;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme coefficients, a load at the top index, extreme samples
    pending_items.push_back(make_coeff(8'd0, 16'h8000));
    pending_items.push_back(make_coeff(8'd1, 16'h7FFF));
    pending_items.push_back(make_coeff(8'd255, 16'h7FFF));
    pending_items.push_back(make_coeff(8'd31, 16'hFFFF));
    for (int k = 0; k < NDEC; k++)
      pending_items.push_back(make_sample(k[0] ? 16'h7FFF : 16'h8000,
                                          k[1] ? 16'h8000 : 16'h7FFF));
    wait_drained();

    // Spread coefficient loads over all branches and tap rows
    for (int k = 0; k < 64; k++)
      pending_items.push_back(make_coeff(8'(4 * k + (k / 8) % 4), rand_value()));
    // Frames with long receiver hold-off, so the block backs up
    for (int k = 0; k < 3 * NDEC; k++)
      pending_items.push_back(make_sample(rand_value(), rand_value()));
    rx_hold = 1;
    repeat (3000) @(posedge clk_i);
    rx_hold = 0;
    wait_drained();

    // Random mix, mostly samples with occasional coefficient updates
    for (int k = 0; k < 120; k++) begin
      if ($urandom_range(0, 9) == 0)
        pending_items.push_back(make_coeff(8'($urandom), rand_value()));
      else
        pending_items.push_back(make_sample(rand_value(), rand_value()));
      if (k == 60) begin
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    end
    // Negative full-scale taps to push the sums to their extremes
    for (int k = 0; k < NBR; k++)
      pending_items.push_back(make_coeff(8'(8 * k), 16'h8000));
    for (int k = 0; k < 2 * NDEC; k++)
      pending_items.push_back(make_sample(16'h8000, 16'h7FFF));
    wait_drained();
    tx_idle_pct = 35;
    rx_idle_pct = 35;
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_outs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Time limit
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
